// File: hw/rtl/vskin_pkg.sv
// Shared types, operation codes and helpers for the vertex skinning unit.
package vskin_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int NORM_W     = 18;
  localparam int DIV_BITS   = 32 + FRAC_BITS;
  localparam int SQRT_STEPS = 32;

  localparam logic [1:0] FUNC_DELTA  = 2'd0;
  localparam logic [1:0] FUNC_VERTEX = 2'd1;
  localparam logic [1:0] FUNC_LOAD   = 2'd2;

  localparam logic [3:0] OP_NOP       = 4'd0;
  localparam logic [3:0] OP_CAPTURE   = 4'd1;
  localparam logic [3:0] OP_LOAD_WR   = 4'd2;
  localparam logic [3:0] OP_DELTA_MUL = 4'd3;
  localparam logic [3:0] OP_ADDBASE   = 4'd4;
  localparam logic [3:0] OP_BLEND_RD  = 4'd5;
  localparam logic [3:0] OP_BLEND_RND = 4'd6;
  localparam logic [3:0] OP_XF_MUL    = 4'd7;
  localparam logic [3:0] OP_XF_SAT    = 4'd8;
  localparam logic [3:0] OP_SQ_MUL    = 4'd9;
  localparam logic [3:0] OP_SQRT_INIT = 4'd10;
  localparam logic [3:0] OP_SQRT_STEP = 4'd11;
  localparam logic [3:0] OP_DIV_INIT  = 4'd12;
  localparam logic [3:0] OP_DIV_STEP  = 4'd13;
  localparam logic [3:0] OP_DIV_DONE  = 4'd14;
  localparam logic [3:0] OP_EMIT      = 4'd15;

  typedef struct packed {
    logic [3:0] op;
    logic [3:0] idx;
    logic [1:0] sub;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       load_ok;
    logic       delta_ok;
    logic [3:0] wzero;
    logic [3:0] idbad;
  } status_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         slot;
    logic [1:0]         row;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] vec_w;
    logic signed [31:0] nrm_x;
    logic signed [31:0] nrm_y;
    logic signed [31:0] nrm_z;
    logic [31:0]        joint_ids;
    logic [63:0]        joint_weights;
  } item_t;

  typedef struct packed {
    logic signed [31:0]       pos_x;
    logic signed [31:0]       pos_y;
    logic signed [31:0]       pos_z;
    logic signed [NORM_W-1:0] norm_x;
    logic signed [NORM_W-1:0] norm_y;
    logic signed [NORM_W-1:0] norm_z;
  } result_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

// File: hw/rtl/vskin_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vskin_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/vskin_dp.sv
// Datapath: joint matrix store, shared multiplier, accumulators, root and divider.
module vskin_dp #(
  parameter int MAX_JOINTS  = 256,
  parameter int MAX_TARGETS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  vskin_pkg::cmd_t       cmd,
  input  vskin_pkg::item_t      in_item,
  input  logic signed [15:0]    tw [4],
  output vskin_pkg::status_t    status,
  output vskin_pkg::result_t    result
);

  localparam int AW = $clog2(MAX_JOINTS * 16);
  localparam int DB = vskin_pkg::DIV_BITS;
  localparam int NW = vskin_pkg::NORM_W;
  localparam int FB = vskin_pkg::FRAC_BITS;
  localparam logic signed [63:0] XF_HALF = 64'sd1 <<< (FB - 1);

  vskin_pkg::item_t it;
  vskin_pkg::cmd_t  s1;
  vskin_pkg::cmd_t  s2;

  logic signed [31:0] vec [4];
  logic signed [31:0] dvec [6];
  logic signed [31:0] acc [6];
  logic signed [31:0] pv [3];
  logic signed [31:0] nv [3];
  logic signed [50:0] bacc [12];
  logic signed [31:0] bm [12];
  logic signed [49:0] xacc;
  logic signed [31:0] tp [3];
  logic signed [31:0] tn [3];
  logic [63:0]        sq;
  logic [63:0]        sv;
  logic [63:0]        sres;
  logic [63:0]        sbit;
  logic [DB-1:0]      num;
  logic [31:0]        rem;
  logic [NW-2:0]      quo;
  logic               dneg;
  logic signed [NW-1:0] nout [3];
  logic signed [63:0] prod;
  logic signed [31:0] ma;
  logic signed [31:0] mb;
  logic [31:0]        rd_data;
  logic [11:0]        wfull;
  logic [11:0]        rfull;
  logic [31:0]        len;

  assign vec[0]  = it.vec_x;
  assign vec[1]  = it.vec_y;
  assign vec[2]  = it.vec_z;
  assign vec[3]  = it.vec_w;
  assign dvec[0] = it.vec_x;
  assign dvec[1] = it.vec_y;
  assign dvec[2] = it.vec_z;
  assign dvec[3] = it.nrm_x;
  assign dvec[4] = it.nrm_y;
  assign dvec[5] = it.nrm_z;
  assign len     = sres[31:0];

  always_ff @(posedge clk) begin
    if (cmd.op == vskin_pkg::OP_CAPTURE) begin
      it <= in_item;
    end
  end

  always_comb begin
    status.func     = it.func;
    status.load_ok  = {1'b0, it.slot} < 9'(MAX_JOINTS);
    status.delta_ok = ({1'b0, it.slot} < 9'(MAX_TARGETS)) && (it.slot < 8'd4) &&
                      (tw[it.slot[1:0]] != 16'sd0);
    for (int j = 0; j < 4; j++) begin
      status.wzero[j] = it.joint_weights[16*j +: 16] == 16'd0;
      status.idbad[j] = {1'b0, it.joint_ids[8*j +: 8]} >= 9'(MAX_JOINTS);
    end
  end

  // Joint matrix rows: joint, row and column form the address directly.
  assign wfull = {it.slot, it.row, cmd.idx[1:0]};
  assign rfull = {it.joint_ids[{cmd.sub, 3'b000} +: 8], cmd.idx};

  vskin_ram #(.WIDTH(32), .DEPTH(MAX_JOINTS * 16)) u_store (
    .clk   (clk),
    .we    (cmd.op == vskin_pkg::OP_LOAD_WR),
    .waddr (wfull[AW-1:0]),
    .wdata (vec[cmd.idx[1:0]]),
    .raddr (rfull[AW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
      s2 <= '0;
    end else begin
      s1 <= cmd;
      s2 <= s1;
    end
  end

  // Multiplier operands, chosen one stage after the command.
  always_comb begin
    ma = '0;
    mb = '0;
    case (s1.op)
      vskin_pkg::OP_DELTA_MUL: begin
        ma = dvec[s1.idx[2:0]];
        mb = 32'(tw[it.slot[1:0]]);
      end
      vskin_pkg::OP_BLEND_RD: begin
        ma = rd_data;
        mb = {16'd0, it.joint_weights[{s1.sub, 4'b0000} +: 16]};
      end
      vskin_pkg::OP_XF_MUL: begin
        ma = bm[{s1.sub, s1.idx[1:0]}];
        case (s1.idx[1:0])
          2'd0:    mb = s1.idx[3] ? nv[0] : pv[0];
          2'd1:    mb = s1.idx[3] ? nv[1] : pv[1];
          default: mb = s1.idx[3] ? nv[2] : pv[2];
        endcase
      end
      vskin_pkg::OP_SQ_MUL: begin
        case (s1.idx[1:0])
          2'd0:    ma = tn[0];
          2'd1:    ma = tn[1];
          default: ma = tn[2];
        endcase
        mb = ma;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  always_ff @(posedge clk) begin
    logic signed [63:0] t;
    logic signed [31:0] tnc;
    logic [31:0]        mag;
    logic [63:0]        trial;
    logic [32:0]        rsh;
    t     = '0;
    tnc   = '0;
    mag   = '0;
    trial = '0;
    rsh   = '0;
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        acc[i] <= '0;
      end
    end else begin
      // Accumulate two stages after a multiply command.
      case (s2.op)
        vskin_pkg::OP_DELTA_MUL: begin
          t = (prod + 64'sd8192) >>> 14;
          acc[s2.idx[2:0]] <= vskin_pkg::sat32(64'(acc[s2.idx[2:0]]) + t);
        end
        vskin_pkg::OP_BLEND_RD: begin
          bacc[s2.idx] <= bacc[s2.idx] + prod[50:0];
        end
        vskin_pkg::OP_XF_MUL: begin
          t = (prod + XF_HALF) >>> FB;
          xacc <= ((s2.idx[1:0] == 2'd0) ? 50'sd0 : xacc) + t[49:0];
        end
        vskin_pkg::OP_SQ_MUL: begin
          sq <= ((s2.idx[1:0] == 2'd0) ? 64'd0 : sq) + prod;
        end
        default: begin
        end
      endcase

      case (cmd.op)
        vskin_pkg::OP_ADDBASE: begin
          for (int i = 0; i < 3; i++) begin
            pv[i] <= vskin_pkg::sat32(64'(dvec[i]) + 64'(acc[i]));
            nv[i] <= vskin_pkg::sat32(64'(dvec[3+i]) + 64'(acc[3+i]));
          end
          for (int i = 0; i < 6; i++) begin
            acc[i] <= '0;
          end
          for (int i = 0; i < 12; i++) begin
            bacc[i] <= '0;
          end
        end
        vskin_pkg::OP_BLEND_RND: begin
          t = (64'(bacc[cmd.idx]) + 64'sd16384) >>> 15;
          bm[cmd.idx] <= vskin_pkg::sat32(t);
        end
        vskin_pkg::OP_XF_SAT: begin
          if (cmd.idx[3]) begin
            tn[cmd.sub] <= vskin_pkg::sat32(64'(xacc));
          end else begin
            tp[cmd.sub] <= vskin_pkg::sat32(64'(xacc) + 64'(bm[{cmd.sub, 2'd3}]));
          end
        end
        vskin_pkg::OP_SQRT_INIT: begin
          sv   <= sq;
          sres <= '0;
          sbit <= 64'h4000_0000_0000_0000;
        end
        vskin_pkg::OP_SQRT_STEP: begin
          trial = sres + sbit;
          if (sv >= trial) begin
            sv   <= sv - trial;
            sres <= (sres >> 1) + sbit;
          end else begin
            sres <= sres >> 1;
          end
          sbit <= sbit >> 2;
        end
        vskin_pkg::OP_DIV_INIT: begin
          case (cmd.idx[1:0])
            2'd0:    tnc = tn[0];
            2'd1:    tnc = tn[1];
            default: tnc = tn[2];
          endcase
          mag  = tnc[31] ? (~tnc + 32'd1) : tnc;
          num  <= {mag, {FB{1'b0}}} + DB'(len >> 1);
          rem  <= '0;
          quo  <= '0;
          dneg <= tnc[31];
        end
        vskin_pkg::OP_DIV_STEP: begin
          rsh = {rem, num[DB-1]};
          num <= num << 1;
          if (rsh >= {1'b0, len}) begin
            rem <= 32'(rsh - {1'b0, len});
            quo <= {quo[NW-3:0], 1'b1};
          end else begin
            rem <= rsh[31:0];
            quo <= {quo[NW-3:0], 1'b0};
          end
        end
        vskin_pkg::OP_DIV_DONE: begin
          if (len == 32'd0) begin
            nout[cmd.idx[1:0]] <= '0;
          end else if (dneg) begin
            nout[cmd.idx[1:0]] <= -$signed({1'b0, quo});
          end else begin
            nout[cmd.idx[1:0]] <= $signed({1'b0, quo});
          end
        end
        vskin_pkg::OP_EMIT: begin
          result.pos_x  <= tp[0];
          result.pos_y  <= tp[1];
          result.pos_z  <= tp[2];
          result.norm_x <= nout[0];
          result.norm_y <= nout[1];
          result.norm_z <= nout[2];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/vskin_ctrl.sv
// Controller: sequences load, delta and vertex work as datapath commands.
module vskin_ctrl #(
  parameter int INFLUENCES = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  vskin_pkg::status_t status,
  output vskin_pkg::cmd_t    cmd
);

  localparam int NI = (INFLUENCES < 4) ? INFLUENCES : 4;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_DISPATCH = 4'd1;
  localparam logic [3:0] ST_LOAD     = 4'd2;
  localparam logic [3:0] ST_DELTA    = 4'd3;
  localparam logic [3:0] ST_DRAIN    = 4'd4;
  localparam logic [3:0] ST_BASE     = 4'd5;
  localparam logic [3:0] ST_BLEND    = 4'd6;
  localparam logic [3:0] ST_BRND     = 4'd7;
  localparam logic [3:0] ST_XF       = 4'd8;
  localparam logic [3:0] ST_XSAT     = 4'd9;
  localparam logic [3:0] ST_SQ       = 4'd10;
  localparam logic [3:0] ST_SQRT     = 4'd11;
  localparam logic [3:0] ST_DIV      = 4'd12;
  localparam logic [3:0] ST_EMIT     = 4'd13;

  logic [3:0] state, state_next;
  logic [3:0] ret, ret_next;
  logic [5:0] cnt, cnt_next;
  logic [2:0] jj, jj_next;
  logic [1:0] rr, rr_next;
  logic       nsel, nsel_next;
  logic       mvalid, mvalid_next;
  logic       emit_fire;

  assign m_tvalid  = mvalid;
  assign s_tready  = state == ST_IDLE;
  assign emit_fire = (state == ST_EMIT) && (!mvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      ret    <= ST_IDLE;
      cnt    <= '0;
      jj     <= '0;
      rr     <= '0;
      nsel   <= 1'b0;
      mvalid <= 1'b0;
    end else begin
      state  <= state_next;
      ret    <= ret_next;
      cnt    <= cnt_next;
      jj     <= jj_next;
      rr     <= rr_next;
      nsel   <= nsel_next;
      mvalid <= mvalid_next;
    end
  end

  always_comb begin
    state_next  = state;
    ret_next    = ret;
    cnt_next    = cnt;
    jj_next     = jj;
    rr_next     = rr;
    nsel_next   = nsel;
    mvalid_next = (mvalid && !m_tready) || emit_fire;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.op     = vskin_pkg::OP_CAPTURE;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cnt_next = '0;
        case (status.func)
          vskin_pkg::FUNC_LOAD:   state_next = status.load_ok ? ST_LOAD : ST_IDLE;
          vskin_pkg::FUNC_DELTA:  state_next = status.delta_ok ? ST_DELTA : ST_IDLE;
          vskin_pkg::FUNC_VERTEX: state_next = ST_BASE;
          default:                state_next = ST_IDLE;
        endcase
      end
      ST_LOAD: begin
        cmd.op  = vskin_pkg::OP_LOAD_WR;
        cmd.idx = cnt[3:0];
        if (cnt == 6'd3) begin
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      ST_DELTA: begin
        cmd.op  = vskin_pkg::OP_DELTA_MUL;
        cmd.idx = cnt[3:0];
        if (cnt == 6'd5) begin
          state_next = ST_DRAIN;
          ret_next   = ST_IDLE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      ST_DRAIN: begin
        if (cnt == 6'd1) begin
          state_next = ret;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      ST_BASE: begin
        cmd.op     = vskin_pkg::OP_ADDBASE;
        jj_next    = '0;
        cnt_next   = '0;
        state_next = ST_BLEND;
      end
      ST_BLEND: begin
        if (jj == 3'(NI) || status.wzero[jj[1:0]]) begin
          state_next = ST_DRAIN;
          ret_next   = ST_BRND;
          cnt_next   = '0;
        end else if (status.idbad[jj[1:0]]) begin
          jj_next = jj + 3'd1;
        end else begin
          cmd.op  = vskin_pkg::OP_BLEND_RD;
          cmd.idx = cnt[3:0];
          cmd.sub = jj[1:0];
          if (cnt == 6'd11) begin
            cnt_next = '0;
            jj_next  = jj + 3'd1;
          end else begin
            cnt_next = cnt + 6'd1;
          end
        end
      end
      ST_BRND: begin
        cmd.op  = vskin_pkg::OP_BLEND_RND;
        cmd.idx = cnt[3:0];
        if (cnt == 6'd11) begin
          state_next = ST_XF;
          cnt_next   = '0;
          rr_next    = '0;
          nsel_next  = 1'b0;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      ST_XF: begin
        cmd.op  = vskin_pkg::OP_XF_MUL;
        cmd.idx = {nsel, 1'b0, cnt[1:0]};
        cmd.sub = rr;
        if (cnt == 6'd2) begin
          state_next = ST_DRAIN;
          ret_next   = ST_XSAT;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      ST_XSAT: begin
        cmd.op  = vskin_pkg::OP_XF_SAT;
        cmd.idx = {nsel, 3'b000};
        cmd.sub = rr;
        if (nsel) begin
          nsel_next = 1'b0;
          if (rr == 2'd2) begin
            state_next = ST_SQ;
          end else begin
            rr_next    = rr + 2'd1;
            state_next = ST_XF;
          end
        end else begin
          nsel_next  = 1'b1;
          state_next = ST_XF;
        end
      end
      ST_SQ: begin
        cmd.op  = vskin_pkg::OP_SQ_MUL;
        cmd.idx = cnt[3:0];
        if (cnt == 6'd2) begin
          state_next = ST_DRAIN;
          ret_next   = ST_SQRT;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      ST_SQRT: begin
        cmd.op = (cnt == 6'd0) ? vskin_pkg::OP_SQRT_INIT : vskin_pkg::OP_SQRT_STEP;
        if (cnt == 6'(vskin_pkg::SQRT_STEPS)) begin
          state_next = ST_DIV;
          cnt_next   = '0;
          rr_next    = '0;
        end else begin
          cnt_next = cnt + 6'd1;
        end
      end
      ST_DIV: begin
        cmd.idx = {2'b00, rr};
        if (cnt == 6'd0) begin
          cmd.op   = vskin_pkg::OP_DIV_INIT;
          cnt_next = cnt + 6'd1;
        end else if (cnt == 6'(vskin_pkg::DIV_BITS + 1)) begin
          cmd.op   = vskin_pkg::OP_DIV_DONE;
          cnt_next = '0;
          if (rr == 2'd2) begin
            state_next = ST_EMIT;
          end else begin
            rr_next = rr + 2'd1;
          end
        end else begin
          cmd.op   = vskin_pkg::OP_DIV_STEP;
          cnt_next = cnt + 6'd1;
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          cmd.op     = vskin_pkg::OP_EMIT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/vertex_skinning_with_morph_targets_unit.sv
// Top level of the vertex skinning unit with morph-target deltas.
//
// Input words arrive on the s_ channel. s_tuser selects the work: a delta word
// scales a morph-target position and normal delta by that target's weight
// register and adds them into six accumulators; a load word writes one row
// of a joint matrix; a vertex word adds its base position and normal to the
// accumulators, blends up to four joint matrices, transforms the position
// and normal, normalizes the normal and puts one result word on the m_ channel.
// Weight registers are written over the APB port; the user must write them
// only while the unit is idle, which the block itself does not enforce.
// One word is worked on at a time. A vertex word blends twelve matrix words
// per used influence and skips an influence with an out-of-range joint; its
// work is paced by the single shared 32x32 multiplier, the 32-step square
// root and three radix-2 divisions of 48 steps. The result sits in an
// output register, so the next input word is taken while it waits; a second
// vertex stalls before its result if the receiver has not yet taken the
// first. Reset clears the weight registers, the accumulators and the
// controller; the matrix store is not cleared.
module vertex_skinning_with_morph_targets_unit #(
  parameter int MAX_JOINTS  = 256,
  parameter int MAX_TARGETS = 4,
  parameter int INFLUENCES  = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // slot[7:0], row[9:8], vec_x, vec_y, vec_z, vec_w, nrm_x, nrm_y, nrm_z
  // (32 bits each from bit 10), joint_ids[265:234], joint_weights[329:266]
  input  logic [335:0] s_tdata,
  // func[1:0]
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], norm_x[113:96],
  // norm_y[131:114], norm_z[149:132]
  output logic [151:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic signed [15:0]   tw [4];
  vskin_pkg::item_t     in_item;
  vskin_pkg::cmd_t      cmd;
  vskin_pkg::status_t   status;
  vskin_pkg::result_t   result;

  // Weight registers, one per 32-bit word of the register space.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        tw[i] <= '0;
      end
    end else if (psel && penable && pwrite) begin
      tw[paddr[3:2]] <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = 32'(tw[paddr[3:2]]);

  assign in_item.func          = s_tuser;
  assign in_item.slot          = s_tdata[7:0];
  assign in_item.row           = s_tdata[9:8];
  assign in_item.vec_x         = s_tdata[41:10];
  assign in_item.vec_y         = s_tdata[73:42];
  assign in_item.vec_z         = s_tdata[105:74];
  assign in_item.vec_w         = s_tdata[137:106];
  assign in_item.nrm_x         = s_tdata[169:138];
  assign in_item.nrm_y         = s_tdata[201:170];
  assign in_item.nrm_z         = s_tdata[233:202];
  assign in_item.joint_ids     = s_tdata[265:234];
  assign in_item.joint_weights = s_tdata[329:266];

  assign m_tdata = {2'b00, result.norm_z, result.norm_y, result.norm_x,
                    result.pos_z, result.pos_y, result.pos_x};

  vskin_ctrl #(.INFLUENCES(INFLUENCES)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  vskin_dp #(.MAX_JOINTS(MAX_JOINTS), .MAX_TARGETS(MAX_TARGETS)) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .in_item (in_item),
    .tw      (tw),
    .status  (status),
    .result  (result)
  );

endmodule

// File: hw/rtl/vskin_checker.sv
// Port-level checker for the vertex skinning unit, bound to the top level.
module vskin_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [151:0] m_tdata
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken twice in a row");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result word appeared while idle");

endmodule

bind vertex_skinning_with_morph_targets_unit vskin_checker u_vskin_checker (.*);

// File: test/tb_top.sv
// Self-checking testbench for the vertex skinning unit with morph-target deltas.
`timescale 1ns / 1ps

module tb_top;

  localparam int NJ = 256;
  localparam logic [3:0] ADDR_TW0 = 4'd0;
  localparam logic [3:0] ADDR_TW1 = 4'd4;
  localparam logic [3:0] ADDR_TW2 = 4'd8;
  localparam logic [3:0] ADDR_TW3 = 4'd12;
  localparam int WATCHDOG = 20000;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [335:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [151:0] m_tdata;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  vertex_skinning_with_morph_targets_unit uut (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow state of the skinning unit.
  logic signed [31:0] mat_shadow [0:NJ*16-1];
  bit                 joint_loaded [0:NJ-1];
  logic signed [31:0] acc_shadow [0:5];
  logic signed [15:0] tw_shadow [0:3];

  vskin_pkg::result_t skinned_q[$];
  int errors = 0;
  int vertices_seen = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  function automatic logic signed [63:0] rshift_round(input logic signed [63:0] v,
                                                      input int s);
    logic signed [63:0] t;
    t = v + (64'sd1 <<< (s - 1));
    return t >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [17:0] unit_of(input logic signed [63:0] n,
                                                 input logic [63:0] len);
    logic [63:0] a, q;
    logic signed [63:0] r;
    a = (n < 0) ? -n : n;
    q = ((a << vskin_pkg::FRAC_BITS) + len / 2) / len;
    r = (n < 0) ? -$signed(q) : $signed(q);
    return r[17:0];
  endfunction

  // Applies one accepted word to the shadow state; returns 1 with a result
  // for a vertex word.
  function automatic bit skin_predict(input vskin_pkg::item_t it,
                                      output vskin_pkg::result_t res);
    logic signed [63:0] p[3], n[3], blend[12], tp[3], tn[3], sp, sn, w;
    logic [63:0] sq, len;
    logic [7:0] id;
    res = '0;
    case (it.func)
      vskin_pkg::FUNC_LOAD: begin
        mat_shadow[it.slot*16 + it.row*4 + 0] = it.vec_x;
        mat_shadow[it.slot*16 + it.row*4 + 1] = it.vec_y;
        mat_shadow[it.slot*16 + it.row*4 + 2] = it.vec_z;
        mat_shadow[it.slot*16 + it.row*4 + 3] = it.vec_w;
        return 0;
      end
      vskin_pkg::FUNC_DELTA: begin
        if (it.slot >= 4) return 0;
        w = tw_shadow[it.slot[1:0]];
        if (w == 0) return 0;
        acc_shadow[0] = clamp32(acc_shadow[0] + rshift_round(it.vec_x * w, 14));
        acc_shadow[1] = clamp32(acc_shadow[1] + rshift_round(it.vec_y * w, 14));
        acc_shadow[2] = clamp32(acc_shadow[2] + rshift_round(it.vec_z * w, 14));
        acc_shadow[3] = clamp32(acc_shadow[3] + rshift_round(it.nrm_x * w, 14));
        acc_shadow[4] = clamp32(acc_shadow[4] + rshift_round(it.nrm_y * w, 14));
        acc_shadow[5] = clamp32(acc_shadow[5] + rshift_round(it.nrm_z * w, 14));
        return 0;
      end
      vskin_pkg::FUNC_VERTEX: begin
        p[0] = clamp32(64'(it.vec_x) + 64'(acc_shadow[0]));
        p[1] = clamp32(64'(it.vec_y) + 64'(acc_shadow[1]));
        p[2] = clamp32(64'(it.vec_z) + 64'(acc_shadow[2]));
        n[0] = clamp32(64'(it.nrm_x) + 64'(acc_shadow[3]));
        n[1] = clamp32(64'(it.nrm_y) + 64'(acc_shadow[4]));
        n[2] = clamp32(64'(it.nrm_z) + 64'(acc_shadow[5]));
        for (int i = 0; i < 12; i++) blend[i] = 0;
        for (int j = 0; j < 4; j++) begin
          w = {48'd0, it.joint_weights[16*j +: 16]};
          id = it.joint_ids[8*j +: 8];
          if (w == 0) break;
          for (int i = 0; i < 12; i++) blend[i] += w * mat_shadow[id*16 + i];
        end
        for (int i = 0; i < 12; i++) blend[i] = clamp32(rshift_round(blend[i], 15));
        for (int r = 0; r < 3; r++) begin
          sp = blend[r*4 + 3];
          sn = 0;
          for (int c = 0; c < 3; c++) begin
            sp += rshift_round(blend[r*4 + c] * p[c], vskin_pkg::FRAC_BITS);
            sn += rshift_round(blend[r*4 + c] * n[c], vskin_pkg::FRAC_BITS);
          end
          tp[r] = clamp32(sp);
          tn[r] = clamp32(sn);
        end
        sq = 0;
        for (int i = 0; i < 3; i++) sq += tn[i] * tn[i];
        len = int_sqrt(sq);
        res.pos_x = tp[0][31:0];
        res.pos_y = tp[1][31:0];
        res.pos_z = tp[2][31:0];
        res.norm_x = (len == 0) ? '0 : unit_of(tn[0], len);
        res.norm_y = (len == 0) ? '0 : unit_of(tn[1], len);
        res.norm_z = (len == 0) ? '0 : unit_of(tn[2], len);
        for (int i = 0; i < 6; i++) acc_shadow[i] = 0;
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  function automatic logic [335:0] pack_word(input vskin_pkg::item_t it);
    return {6'd0, it.joint_weights, it.joint_ids, it.nrm_z, it.nrm_y, it.nrm_x,
            it.vec_w, it.vec_z, it.vec_y, it.vec_x, it.row, it.slot};
  endfunction

  function automatic logic [31:0] rnd32();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
      3: return {{14{$urandom_range(0, 1) == 1}}, 18'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // A vertex may only name joints whose four rows were written, until the
  // first zero weight. Unloaded ids get a loaded substitute.
  function automatic vskin_pkg::item_t legal_vertex(input vskin_pkg::item_t it);
    for (int j = 0; j < 4; j++) begin
      if (it.joint_weights[16*j +: 16] == 0) break;
      if (!joint_loaded[it.joint_ids[8*j +: 8]]) it.joint_ids[8*j +: 8] = 8'd0;
    end
    return it;
  endfunction

  // Receiver: stalls at random and checks every result word in order.
  always @(posedge clk) begin
    vskin_pkg::result_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.pos_x  = m_tdata[31:0];
        got.pos_y  = m_tdata[63:32];
        got.pos_z  = m_tdata[95:64];
        got.norm_x = m_tdata[113:96];
        got.norm_y = m_tdata[131:114];
        got.norm_z = m_tdata[149:132];
        if (skinned_q.size() == 0) begin
          $error("result word with no vertex outstanding");
          errors++;
        end else begin
          want = skinned_q.pop_front();
          vertices_seen++;
          if (got.pos_x !== want.pos_x) begin
            $error("pos_x expected %0d got %0d", want.pos_x, got.pos_x); errors++;
          end
          if (got.pos_y !== want.pos_y) begin
            $error("pos_y expected %0d got %0d", want.pos_y, got.pos_y); errors++;
          end
          if (got.pos_z !== want.pos_z) begin
            $error("pos_z expected %0d got %0d", want.pos_z, got.pos_z); errors++;
          end
          if (got.norm_x !== want.norm_x) begin
            $error("norm_x expected %0d got %0d", want.norm_x, got.norm_x); errors++;
          end
          if (got.norm_y !== want.norm_y) begin
            $error("norm_y expected %0d got %0d", want.norm_y, got.norm_y); errors++;
          end
          if (got.norm_z !== want.norm_z) begin
            $error("norm_z expected %0d got %0d", want.norm_z, got.norm_z); errors++;
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: counts cycles with no word moving on either channel.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("vertex_skinning_with_morph_targets_unit regression: fail");
        $finish;
      end
    end
  end

  // Waits for a clock edge before driving so that no bus signal is driven twice
  // in the same time step.
  task automatic apb_write(input logic [3:0] addr, input logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr;
    pwdata <= {{16{val[15]}}, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    tw_shadow[addr[3:2]] = val;
  endtask

  // Sends one word, random gaps before it; predicts at acceptance. The unit
  // is never ready in the cycle after an accept, so the leading edge costs
  // no throughput.
  task automatic send_word(input vskin_pkg::item_t it);
    vskin_pkg::result_t r;
    @(posedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= pack_word(it);
    s_tuser <= it.func;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (skin_predict(it, r)) skinned_q.push_back(r);
    if (it.func == vskin_pkg::FUNC_LOAD) joint_loaded[it.slot] = 1;
    items_sent++;
    s_tvalid <= 1'b0;
  endtask

  // Waits for every vertex result, then for the longest vertex latency.
  task automatic drain();
    while (skinned_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic load_joint(input logic [7:0] j, input bit ident);
    vskin_pkg::item_t it;
    for (int r = 0; r < 4; r++) begin
      it = '0;
      it.func = vskin_pkg::FUNC_LOAD; it.slot = j; it.row = r[1:0];
      if (ident) begin
        it.vec_x = (r == 0) ? 32'h10000 : 0;
        it.vec_y = (r == 1) ? 32'h10000 : 0;
        it.vec_z = (r == 2) ? 32'h10000 : 0;
        it.vec_w = 0;
      end else begin
        it.vec_x = rnd32(); it.vec_y = rnd32(); it.vec_z = rnd32(); it.vec_w = rnd32();
        it.nrm_x = $urandom; it.joint_weights = {$urandom, $urandom};
      end
      send_word(it);
    end
  endtask

  function automatic vskin_pkg::item_t random_word();
    vskin_pkg::item_t it;
    it.func = ($urandom_range(0, 99) < 5) ? FUNC_UNUSED :
              ($urandom_range(0, 1) ? vskin_pkg::FUNC_VERTEX : vskin_pkg::FUNC_DELTA);
    it.slot = $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3));
    it.row = 2'($urandom);
    it.vec_x = rnd32(); it.vec_y = rnd32(); it.vec_z = rnd32(); it.vec_w = $urandom;
    it.nrm_x = rnd32(); it.nrm_y = rnd32(); it.nrm_z = rnd32();
    it.joint_ids = $urandom;
    it.joint_weights = {$urandom, $urandom};
    for (int j = 0; j < 4; j++)
      if ($urandom_range(0, 5) == 0) it.joint_weights[16*j +: 16] = 0;
    if (it.func == vskin_pkg::FUNC_VERTEX) it = legal_vertex(it);
    return it;
  endfunction

  // Directed table row: word plus an optional typed-in expectation.
  typedef struct {
    vskin_pkg::item_t   it;
    bit                 known;
    vskin_pkg::result_t res;
  } row_t;

  initial begin
    row_t dir_tab[$];
    row_t rw;
    int sent_phase;
    for (int i = 0; i < NJ*16; i++) mat_shadow[i] = 0;
    for (int i = 0; i < NJ; i++) joint_loaded[i] = 0;
    for (int i = 0; i < 6; i++) acc_shadow[i] = 0;
    for (int i = 0; i < 4; i++) tw_shadow[i] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: identity matrices on joints 0 and 255, then extremes.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_joint(8'd0, 1);
    load_joint(8'd255, 1);

    // A vertex with zero first weight gives a zero result.
    rw = '{default: '0};
    rw.it.func = vskin_pkg::FUNC_VERTEX; rw.it.vec_x = 32'h7fffffff;
    rw.it.nrm_x = 32'h10000;
    rw.known = 1; rw.res = '0;
    dir_tab.push_back(rw);
    // Identity joint at full weight passes the position; normal becomes +x unit.
    rw = '{default: '0};
    rw.it.func = vskin_pkg::FUNC_VERTEX; rw.it.vec_x = 32'h00030000;
    rw.it.vec_y = 32'h80000000;
    rw.it.vec_z = 32'h7fffffff; rw.it.nrm_x = 32'h00050000;
    rw.it.joint_weights = 64'h8000;
    rw.known = 1;
    rw.res.pos_x = 32'h00030000; rw.res.pos_y = 32'h80000000; rw.res.pos_z = 32'h7fffffff;
    rw.res.norm_x = 18'h10000;
    dir_tab.push_back(rw);
    // Degenerate normal gives zero normal fields.
    rw = '{default: '0};
    rw.it.func = vskin_pkg::FUNC_VERTEX; rw.it.vec_y = 32'h00010000;
    rw.it.joint_ids = 32'h000000ff; rw.it.joint_weights = 64'h8000;
    rw.known = 1; rw.res.pos_y = 32'h00010000;
    dir_tab.push_back(rw);
    // Delta with zero weight, delta to an out-of-range target, unused func.
    rw = '{default: '0};
    rw.it.func = vskin_pkg::FUNC_DELTA; rw.it.vec_x = 32'h7fffffff;
    dir_tab.push_back(rw);
    rw.it.slot = 8'd200; dir_tab.push_back(rw);
    rw.it.func = FUNC_UNUSED; rw.it.slot = 8'hff; rw.it.row = 2'd3;
    rw.it.vec_w = '1; rw.it.nrm_z = '1; rw.it.joint_ids = '1; rw.it.joint_weights = '1;
    dir_tab.push_back(rw);
    // Weights cover every byte; a weight of all ones and later zero weight.
    rw = '{default: '0};
    rw.it.func = vskin_pkg::FUNC_VERTEX; rw.it.vec_x = 32'hffff0000;
    rw.it.nrm_z = 32'h80000000;
    rw.it.joint_ids = 32'h00ff00ff; rw.it.joint_weights = 64'h0000_ffff_ffff_ffff;
    dir_tab.push_back(rw);
    rw.it.nrm_y = 32'h7fffffff; rw.it.joint_weights = 64'hffff_ffff_ffff_ffff;
    rw.it.joint_ids = 32'hff00ff00;
    dir_tab.push_back(rw);
    foreach (dir_tab[k]) begin
      send_word(dir_tab[k].it);
      if (dir_tab[k].known) begin
        // Replace the predicted entry by the typed one for a hard check.
        skinned_q[skinned_q.size()-1] = dir_tab[k].res;
      end
    end
    drain();

    // Target weights at extremes, then deltas on each target.
    apb_write(ADDR_TW0, 16'h7fff);
    apb_write(ADDR_TW1, 16'h8000);
    apb_write(ADDR_TW2, 16'h4000);
    apb_write(ADDR_TW3, 16'hffff);
    for (int t = 0; t < 4; t++) begin
      rw = '{default: '0};
      rw.it.func = vskin_pkg::FUNC_DELTA; rw.it.slot = t[7:0];
      rw.it.vec_x = 32'h7fffffff; rw.it.vec_y = 32'h80000000; rw.it.vec_z = 32'h12345;
      rw.it.nrm_x = 32'h80000000; rw.it.nrm_y = 32'h7fffffff; rw.it.nrm_z = 32'h10000;
      send_word(rw.it);
    end
    rw.it.func = vskin_pkg::FUNC_VERTEX; rw.it.joint_weights = 64'h8000;
    send_word(rw.it);
    drain();

    // Random part in three idling phases, with weight settings between.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 38 : (phase == 1) ? 63 : 0;
      recv_idle_pct = (phase == 0) ? 63 : (phase == 1) ? 38 : 0;
      apb_write(ADDR_TW0, 16'($urandom));
      apb_write(ADDR_TW1, (phase == 2) ? 16'h0000 : 16'($urandom));
      apb_write(ADDR_TW2, 16'($urandom_range(0, 1) ? 16'h7fff : 16'h8000));
      apb_write(ADDR_TW3, 16'($urandom));
      for (int k = 0; k < 3; k++) load_joint(8'($urandom), 0);
      sent_phase = 0;
      while (sent_phase < 230) begin
        if ($urandom_range(0, 19) == 0) begin
          load_joint(8'($urandom), $urandom_range(0, 1));
          sent_phase += 4;
        end else begin
          send_word(random_word());
          sent_phase++;
        end
        // Occasionally hold off until every outstanding vertex has returned.
        if ($urandom_range(0, 49) == 0)
          while (skinned_q.size() != 0) @(posedge clk);
      end
      drain();
    end

    $display("covered %0d input words and %0d checked vertices over three idling phases",
             items_sent, vertices_seen);
    if (errors == 0 && skinned_q.size() == 0) begin
      $display("vertex_skinning_with_morph_targets_unit regression: pass");
    end else begin
      $display("vertex_skinning_with_morph_targets_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/vskin_pkg.sv
hw/rtl/vskin_ram.sv
hw/rtl/vskin_dp.sv
hw/rtl/vskin_ctrl.sv
hw/rtl/vertex_skinning_with_morph_targets_unit.sv
hw/rtl/vskin_checker.sv
test/tb_top.sv
